@@ rtl/sorted_table_char_encoder_macros.svh @@
// Assertion macros for the sorted table character encoder.
// Depends on nothing; included by the top level only.
`ifndef SORTED_TABLE_CHAR_ENCODER_MACROS_SVH
`define SORTED_TABLE_CHAR_ENCODER_MACROS_SVH

// antecedent holds -> consequent in the same cycle
`define STCE_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent holds -> consequent in the next cycle
`define STCE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/stce_pkg.sv @@
// Package for the sorted table character encoder: widths, codes, state type.
// Depends on nothing; imported by sorted_table_char_encoder.
package stce_pkg;

    localparam int TABLE_DEPTH = 256;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 16;
    localparam int BYTE_W      = 8;
    localparam int IDX_W       = 8;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 9;

    localparam logic [BYTE_W-1:0] REPLACEMENT_BYTE = 8'h3F;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_XLATE = 1'b1;

    localparam logic MODE_REPLACE = 1'b0;
    localparam logic MODE_ERROR   = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_ENTRIES_USED = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_UNREP_MODE   = 1'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DONE
    } state_t;

endpackage

@@ rtl/sorted_table_char_encoder.sv @@
// Sorted table character encoder: table memory, binary search sequencer, output register.
// Depends on stce_pkg and sorted_table_char_encoder_macros.svh.
//
// Usage:
//   Input words on s_* (valid/ready). A write word (opcode write) stores key and byte
//   in the slot given by s_entry_index and produces no result.
//   A translate word binary-searches the first entries_used slots, which must hold
//   keys in ascending order, and produces one result word on m_* (valid/ready).
//   Configuration: cfg_wr_en with cfg_index selects entries_used or unrep_mode;
//   write only while the block is idle.
//   Timing: one shared key comparator reads one table entry per cycle from a
//   registered-read memory; a translate makes k probes (at most floor(log2(n)) + 1,
//   i.e. 9 for 256 entries). The result is registered after the last compare; if the
//   output register is free, s_ready returns in the same cycle as m_valid.
//   Reset: entries_used = 1, unrep_mode = replace, no result pending. The table is
//   not cleared; every searched slot must be written first.
//   Stall: a result waiting on m_ready sits in the output register; a following
//   search runs meanwhile and holds its result until the output register frees.
`include "sorted_table_char_encoder_macros.svh"

module sorted_table_char_encoder
    import stce_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_opcode,
    input  logic [IDX_W-1:0]      s_entry_index,
    input  logic [KEY_W-1:0]      s_key_char,
    input  logic [BYTE_W-1:0]     s_entry_byte,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_out_byte,
    output logic                  m_unrepresentable,
    output logic                  m_error
);

    logic [KEY_W+BYTE_W-1:0] table_mem [TABLE_DEPTH];

    state_t                  state_reg, state_next;
    logic [CFG_DATA_W-1:0]   entries_used_reg;
    logic                    unrep_mode_reg;
    logic [KEY_W-1:0]        key_reg;
    logic [CNT_W-1:0]        lo_reg, lo_next;
    logic [CNT_W-1:0]        hi_reg, hi_next;
    logic [ADDR_W-1:0]       mid_reg, mid_next;
    logic [KEY_W+BYTE_W-1:0] rd_data_reg;
    logic [BYTE_W-1:0]       res_byte_reg, res_byte_next;
    logic                    res_unrep_reg, res_unrep_next;
    logic                    res_err_reg, res_err_next;
    logic                    m_valid_reg, m_valid_next;
    logic [BYTE_W-1:0]       m_byte_reg;
    logic                    m_unrep_reg;
    logic                    m_err_reg;

    logic                    s_accept;
    logic                    out_free;
    logic                    rd_en;
    logic                    res_load;
    logic                    out_load;
    logic [CNT_W-1:0]        n_sat;
    logic [CNT_W:0]          init_sum;
    logic [CNT_W:0]          step_sum;
    logic [CNT_W-1:0]        lo_step, hi_step;
    logic [KEY_W-1:0]        rd_key;
    logic [BYTE_W-1:0]       rd_byte;
    logic [BYTE_W-1:0]       found_byte;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign rd_key   = rd_data_reg[KEY_W+BYTE_W-1:BYTE_W];
    assign rd_byte  = rd_data_reg[BYTE_W-1:0];

    assign m_valid           = m_valid_reg;
    assign m_out_byte        = m_byte_reg;
    assign m_unrepresentable = m_unrep_reg;
    assign m_error           = m_err_reg;

    always_comb begin
        if (32'(entries_used_reg) > TABLE_DEPTH) begin
            n_sat = CNT_W'(TABLE_DEPTH);
        end else begin
            n_sat = CNT_W'(entries_used_reg);
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_opcode == OP_XLATE) begin
                    if (res_load) begin
                        state_next = out_free ? ST_IDLE : ST_DONE;
                    end else begin
                        state_next = ST_SEARCH;
                    end
                end
            end
            ST_SEARCH: begin
                if (res_load) begin
                    state_next = out_free ? ST_IDLE : ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // search datapath and result
    always_comb begin
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        mid_next   = mid_reg;
        rd_en      = 1'b0;
        res_load   = 1'b0;
        found_byte = '0;
        init_sum   = {1'b0, n_sat} - (CNT_W+1)'(1);
        step_sum   = '0;
        lo_step    = lo_reg;
        hi_step    = hi_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_accept && s_opcode == OP_XLATE) begin
                    lo_next  = '0;
                    hi_next  = n_sat;
                    mid_next = ADDR_W'(init_sum >> 1);
                    if (n_sat == '0) begin
                        res_load = 1'b1;
                    end else begin
                        rd_en = 1'b1;
                    end
                end
            end
            ST_SEARCH: begin
                if (key_reg == rd_key) begin
                    res_load   = 1'b1;
                    found_byte = rd_byte;
                end else begin
                    if (key_reg > rd_key) begin
                        lo_step = CNT_W'(mid_reg) + CNT_W'(1);
                    end else begin
                        hi_step = CNT_W'(mid_reg);
                    end
                    lo_next  = lo_step;
                    hi_next  = hi_step;
                    step_sum = {1'b0, lo_step} + {1'b0, hi_step} - (CNT_W+1)'(1);
                    if (lo_step < hi_step) begin
                        mid_next = ADDR_W'(step_sum >> 1);
                        rd_en    = 1'b1;
                    end else begin
                        res_load = 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase

        if (found_byte != '0) begin
            res_byte_next  = found_byte;
            res_unrep_next = 1'b0;
            res_err_next   = 1'b0;
        end else if (unrep_mode_reg == MODE_REPLACE) begin
            res_byte_next  = REPLACEMENT_BYTE;
            res_unrep_next = 1'b1;
            res_err_next   = 1'b0;
        end else begin
            res_byte_next  = '0;
            res_unrep_next = 1'b1;
            res_err_next   = 1'b1;
        end

        out_load     = (res_load || state_reg == ST_DONE) && out_free;
        m_valid_next = out_load ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    // table memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (s_accept && s_opcode == OP_WRITE && 32'(s_entry_index) < TABLE_DEPTH) begin
            table_mem[ADDR_W'(s_entry_index)] <= {s_key_char, s_entry_byte};
        end
        if (rd_en) begin
            rd_data_reg <= table_mem[mid_next];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            key_reg <= s_key_char;
        end
        lo_reg  <= lo_next;
        hi_reg  <= hi_next;
        mid_reg <= mid_next;
        if (res_load) begin
            res_byte_reg  <= res_byte_next;
            res_unrep_reg <= res_unrep_next;
            res_err_reg   <= res_err_next;
        end
        if (out_load) begin
            if (state_reg == ST_DONE) begin
                m_byte_reg  <= res_byte_reg;
                m_unrep_reg <= res_unrep_reg;
                m_err_reg   <= res_err_reg;
            end else begin
                m_byte_reg  <= res_byte_next;
                m_unrep_reg <= res_unrep_next;
                m_err_reg   <= res_err_next;
            end
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ST_IDLE;
            m_valid_reg      <= 1'b0;
            entries_used_reg <= CFG_DATA_W'(1);
            unrep_mode_reg   <= MODE_REPLACE;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_ENTRIES_USED: entries_used_reg <= cfg_wdata;
                    CFG_UNREP_MODE:   unrep_mode_reg   <= cfg_wdata[0];
                    default: begin
                    end
                endcase
            end
        end
    end

    `STCE_ASSERT_SAME(a_window_open, aclk, aresetn,
        state_reg == ST_SEARCH,
        lo_reg < hi_reg && hi_reg <= CNT_W'(TABLE_DEPTH),
        "search window empty or beyond table")
    `STCE_ASSERT_SAME(a_mid_in_window, aclk, aresetn,
        state_reg == ST_SEARCH,
        CNT_W'(mid_reg) >= lo_reg && CNT_W'(mid_reg) < hi_reg,
        "probe outside search window")
    `STCE_ASSERT_SAME(a_err_implies_unrep, aclk, aresetn,
        m_valid_reg && m_err_reg,
        m_unrep_reg && m_byte_reg == '0,
        "error flag without unrepresentable result")
    `STCE_ASSERT_NEXT(a_xlate_busy, aclk, aresetn,
        s_accept && s_opcode == OP_XLATE,
        state_reg != ST_IDLE || m_valid_reg,
        "translate word produced no result and no search")

endmodule
